FILE: sv/hrp_pkg.sv
package hrp_pkg;

   // Parser phases, one per position in the request-head grammar.
   typedef enum logic [3:0] {
      PH_METHOD     = 4'd0,
      PH_TARGET     = 4'd1,
      PH_VERSION    = 4'd2,
      PH_START_CR   = 4'd3,
      PH_START_LF   = 4'd4,
      PH_LINE       = 4'd5,
      PH_NAME       = 4'd6,
      PH_NAME_COLON = 4'd7,
      PH_VALUE_SP   = 4'd8,
      PH_VALUE      = 4'd9,
      PH_VALUE_LF   = 4'd10,
      PH_BLANK_LF   = 4'd11,
      PH_BODY       = 4'd12
   } phase_type;

   // Result event kinds.
   localparam logic [1:0] EV_START_LINE = 2'd0;
   localparam logic [1:0] EV_HEADER     = 2'd1;
   localparam logic [1:0] EV_BODY       = 2'd2;
   localparam logic [1:0] EV_ERROR      = 2'd3;

   localparam int unsigned METHOD_COUNT = 9;
   localparam logic [METHOD_COUNT-1:0] ALL_METHODS = '1;
   localparam logic [2:0] VERSION_LEN = 3'd7;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ONE   = 8'h31;

   typedef struct packed {
      logic [1:0]  event_kind;
      logic [3:0]  method_code;
      logic [11:0] first_start;
      logic [11:0] first_end;
      logic [11:0] second_start;
      logic [11:0] second_end;
      logic [4:0]  header_number;
   } result_type;

   // Method name, left aligned in eight character slots.
   function automatic logic [63:0] method_text(input logic [3:0] idx);
      logic [63:0] txt;
      unique case (idx)
         4'd0:    txt = {"GET", 40'd0};
         4'd1:    txt = {"POST", 32'd0};
         4'd2:    txt = {"PUT", 40'd0};
         4'd3:    txt = {"DELETE", 16'd0};
         4'd4:    txt = {"OPTIONS", 8'd0};
         4'd5:    txt = {"HEAD", 32'd0};
         4'd6:    txt = {"CONNECT", 8'd0};
         4'd7:    txt = {"PATCH", 24'd0};
         4'd8:    txt = {"TRACE", 24'd0};
         default: txt = '0;
      endcase
      return txt;
   endfunction

   function automatic logic [2:0] method_len(input logic [3:0] idx);
      logic [2:0] len;
      unique case (idx)
         4'd0, 4'd2:       len = 3'd3;
         4'd1, 4'd5:       len = 3'd4;
         4'd3:             len = 3'd6;
         4'd4, 4'd6:       len = 3'd7;
         4'd7, 4'd8:       len = 3'd5;
         default:          len = 3'd0;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] method_char(input logic [3:0] idx, input logic [2:0] pos);
      logic [63:0] txt;
      txt = method_text(idx);
      return txt[63 - 8 * pos -: 8];
   endfunction

   function automatic logic [7:0] version_char(input logic [2:0] pos);
      logic [63:0] txt;
      txt = {"HTTP/1.", 8'd0};
      return txt[63 - 8 * pos -: 8];
   endfunction

endpackage

FILE: sv/http_request_head_parser.sv
// Byte-serial parser for the head of an HTTP/1.x request.
// The req_ channel carries one request byte per beat, with req_last_byte
// set on the final byte of the request. The rsp_ channel carries at most one
// event per input beat: the start line (method code and target span) when
// its LF arrives, each header (name and value spans, header index) when its
// LF arrives, the body span on the last byte, or a parse error. After an
// error, bytes are swallowed silently up to the last byte of the request.
// All offsets count bytes from the first byte of the request, ends exclusive.
// A byte is held in the input register until the parser consumes it, and
// its event is loaded into the event register as it is consumed; that waits
// while the receiver holds back an event already in the event register.
// One byte can be accepted every cycle while the receiver takes events;
// the parser state update between the two registers is combinational.
// Reset clears both valid flags and returns the parser to the method phase;
// the parser also rearms itself after every last byte.
// When the receiver stalls with an event pending, the next byte may still
// move into the input register, and further bytes wait in req_ until the
// event beat is taken.
module http_request_head_parser #(
   parameter int unsigned BUF_BYTES   = 2048,
   parameter int unsigned MAX_HEADERS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_event_kind,
   output logic [3:0]  rsp_method_code,
   output logic [11:0] rsp_first_start,
   output logic [11:0] rsp_first_end,
   output logic [11:0] rsp_second_start,
   output logic [11:0] rsp_second_end,
   output logic [4:0]  rsp_header_number
);
   import hrp_pkg::*;

   // Input register: holds one accepted byte until the parser consumes it.
   logic       in_valid_ff;
   logic [7:0] in_data_ff;
   logic       in_last_ff;

   // Event register toward the receiver.
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_res_ff;

   logic       proc_en;
   logic       core_valid;
   result_type core_res;

   // The parser consumes the held byte whenever the event register is free
   // or is being emptied this cycle; a byte that makes no event waits as well.
   assign proc_en   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || proc_en;

   hrp_core #(
      .BUF_BYTES   (BUF_BYTES),
      .MAX_HEADERS (MAX_HEADERS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (proc_en),
      .data_byte (in_data_ff),
      .last_byte (in_last_ff),
      .res_valid (core_valid),
      .res       (core_res)
   );

   always_comb begin
      if (proc_en && core_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers load without reset; their valid flags qualify them.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      if (proc_en && core_valid) begin
         rsp_res_ff <= core_res;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_kind    = rsp_res_ff.event_kind;
   assign rsp_method_code   = rsp_res_ff.method_code;
   assign rsp_first_start   = rsp_res_ff.first_start;
   assign rsp_first_end     = rsp_res_ff.first_end;
   assign rsp_second_start  = rsp_res_ff.second_start;
   assign rsp_second_end    = rsp_res_ff.second_end;
   assign rsp_header_number = rsp_res_ff.header_number;

   // A held byte must not be consumed or replaced while the event register
   // is blocked by the receiver.
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid_ff && !rsp_ready)
         |=> (in_valid_ff && $stable(in_data_ff) && $stable(in_last_ff)))
      else $error("input byte lost while event register stalled");

   // Error events carry no spans and no codes.
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_kind == EV_ERROR)
         |-> (rsp_method_code == 4'd0 && rsp_first_start == 12'd0 &&
              rsp_first_end == 12'd0 && rsp_second_start == 12'd0 &&
              rsp_second_end == 12'd0 && rsp_header_number == 5'd0))
      else $error("error event with nonzero fields");

   // Only header events use the value span and the header index.
   a_start_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_event_kind == EV_START_LINE || rsp_event_kind == EV_BODY))
         |-> (rsp_second_start == 12'd0 && rsp_second_end == 12'd0 &&
              rsp_header_number == 5'd0))
      else $error("start line or body event with header fields set");

   // Header and body events never carry a method code.
   a_method_only_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_event_kind == EV_HEADER || rsp_event_kind == EV_BODY))
         |-> (rsp_method_code == 4'd0))
      else $error("method code outside a start line event");

endmodule

FILE: sv/hrp_core.sv
module hrp_core #(
   parameter int unsigned BUF_BYTES   = 2048,
   parameter int unsigned MAX_HEADERS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic [7:0]          data_byte,
   input  logic                last_byte,
   output logic                res_valid,
   output hrp_pkg::result_type res
);
   import hrp_pkg::*;

   localparam int unsigned OW = $clog2(BUF_BYTES + 1);
   localparam int unsigned HW = $clog2(MAX_HEADERS + 1);

   phase_type               phase_ff, phase_in;
   logic [OW-1:0]           offset_ff, offset_in;
   logic [2:0]              kstep_ff, kstep_in;
   logic [METHOD_COUNT-1:0] cand_ff, cand_in;
   logic [OW-1:0]           target_begin_ff, target_begin_in;
   logic [OW-1:0]           name_begin_ff, name_begin_in;
   logic [OW-1:0]           name_finish_ff, name_finish_in;
   logic [OW-1:0]           value_begin_ff, value_begin_in;
   logic [HW-1:0]           headers_ff, headers_in;
   logic [OW-1:0]           body_begin_ff, body_begin_in;
   logic                    drop_ff, drop_in;

   logic [METHOD_COUNT-1:0] keep_vec, hit_vec;
   logic [3:0]              method_idx;
   logic                    adv_err, adv_event, reset_all;
   result_type              ev_res;

   function automatic logic [11:0] span12(input logic [OW-1:0] v);
      logic [OW+11:0] w;
      w = {12'd0, v};
      return w[11:0];
   endfunction

   function automatic logic [4:0] hdr5(input logic [HW-1:0] v);
      logic [HW+4:0] w;
      w = {5'd0, v};
      return w[4:0];
   endfunction

   // Compare the byte against every live method name in parallel.
   always_comb begin
      keep_vec = '0;
      hit_vec  = '0;
      for (int i = 0; i < METHOD_COUNT; i++) begin
         if (cand_ff[i]) begin
            if (kstep_ff == method_len(4'(i))) begin
               hit_vec[i] = (data_byte == CH_SPACE);
            end else if (kstep_ff < method_len(4'(i)) &&
                         method_char(4'(i), kstep_ff) == data_byte) begin
               keep_vec[i] = 1'b1;
            end
         end
      end
   end

   // Code of the lowest live candidate; a single one is left by the start line.
   always_comb begin
      method_idx = '0;
      for (int i = METHOD_COUNT - 1; i >= 0; i--) begin
         if (cand_ff[i]) begin
            method_idx = 4'(i);
         end
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      offset_in       = offset_ff;
      kstep_in        = kstep_ff;
      cand_in         = cand_ff;
      target_begin_in = target_begin_ff;
      name_begin_in   = name_begin_ff;
      name_finish_in  = name_finish_ff;
      value_begin_in  = value_begin_ff;
      headers_in      = headers_ff;
      body_begin_in   = body_begin_ff;
      drop_in         = drop_ff;
      adv_err         = 1'b0;
      adv_event       = 1'b0;
      reset_all       = 1'b0;
      ev_res          = '0;
      res_valid       = 1'b0;
      res             = '0;

      if (step_en) begin
         if (drop_ff) begin
            reset_all = last_byte;
         end else begin
            if (offset_ff >= OW'(BUF_BYTES)) begin
               adv_err = 1'b1;
            end else begin
               offset_in = offset_ff + 1'b1;
               unique case (phase_ff)
                  PH_METHOD: begin
                     if (|hit_vec) begin
                        cand_in         = hit_vec;
                        target_begin_in = offset_ff + 1'b1;
                        kstep_in        = '0;
                        phase_in        = PH_TARGET;
                     end else if (keep_vec == '0) begin
                        adv_err = 1'b1;
                     end else begin
                        cand_in  = keep_vec;
                        kstep_in = kstep_ff + 1'b1;
                     end
                  end
                  PH_TARGET: begin
                     if (data_byte == CH_SPACE) begin
                        name_finish_in = offset_ff;
                        kstep_in       = '0;
                        phase_in       = PH_VERSION;
                     end
                  end
                  PH_VERSION: begin
                     if (kstep_ff < VERSION_LEN) begin
                        if (version_char(kstep_ff) != data_byte) begin
                           adv_err = 1'b1;
                        end else begin
                           kstep_in = kstep_ff + 1'b1;
                        end
                     end else if (data_byte != CH_ONE && data_byte != CH_ZERO) begin
                        adv_err = 1'b1;
                     end else begin
                        kstep_in = '0;
                        phase_in = PH_START_CR;
                     end
                  end
                  PH_START_CR: begin
                     if (data_byte != CH_CR) adv_err = 1'b1;
                     else phase_in = PH_START_LF;
                  end
                  PH_START_LF: begin
                     if (data_byte != CH_LF) begin
                        adv_err = 1'b1;
                     end else begin
                        adv_event          = 1'b1;
                        ev_res.event_kind  = EV_START_LINE;
                        ev_res.method_code = method_idx;
                        ev_res.first_start = span12(target_begin_ff);
                        ev_res.first_end   = span12(name_finish_ff);
                        phase_in           = PH_LINE;
                     end
                  end
                  PH_LINE: begin
                     if (data_byte == CH_CR) begin
                        phase_in = PH_BLANK_LF;
                     end else if (headers_ff >= HW'(MAX_HEADERS)) begin
                        adv_err = 1'b1;
                     end else begin
                        name_begin_in = offset_ff;
                        phase_in      = PH_NAME;
                     end
                  end
                  PH_NAME: begin
                     if (data_byte == CH_COLON) begin
                        name_finish_in = offset_ff;
                        phase_in       = PH_VALUE_SP;
                     end else if (data_byte == CH_SPACE) begin
                        name_finish_in = offset_ff;
                        phase_in       = PH_NAME_COLON;
                     end
                  end
                  PH_NAME_COLON: begin
                     if (data_byte != CH_COLON) adv_err = 1'b1;
                     else phase_in = PH_VALUE_SP;
                  end
                  PH_VALUE_SP: begin
                     if (data_byte != CH_SPACE) begin
                        adv_err = 1'b1;
                     end else begin
                        value_begin_in = offset_ff + 1'b1;
                        phase_in       = PH_VALUE;
                     end
                  end
                  PH_VALUE: begin
                     if (data_byte == CH_CR) phase_in = PH_VALUE_LF;
                  end
                  PH_VALUE_LF: begin
                     if (data_byte != CH_LF) begin
                        adv_err = 1'b1;
                     end else begin
                        adv_event            = 1'b1;
                        ev_res.event_kind    = EV_HEADER;
                        ev_res.first_start   = span12(name_begin_ff);
                        ev_res.first_end     = span12(name_finish_ff);
                        ev_res.second_start  = span12(value_begin_ff);
                        ev_res.second_end    = span12(offset_ff - 1'b1);
                        ev_res.header_number = hdr5(headers_ff);
                        headers_in           = headers_ff + 1'b1;
                        phase_in             = PH_LINE;
                     end
                  end
                  PH_BLANK_LF: begin
                     if (data_byte != CH_LF) begin
                        adv_err = 1'b1;
                     end else begin
                        body_begin_in = offset_ff + 1'b1;
                        phase_in      = PH_BODY;
                     end
                  end
                  PH_BODY: begin
                  end
                  default: adv_err = 1'b1;
               endcase
            end

            if (adv_err) begin
               res_valid      = 1'b1;
               res.event_kind = EV_ERROR;
               reset_all      = last_byte;
               drop_in        = !last_byte;
            end else if (last_byte) begin
               // The last byte closes the request: a body span if the head
               // was complete, otherwise the request ended early.
               res_valid = 1'b1;
               reset_all = 1'b1;
               if (phase_in == PH_BODY) begin
                  res.event_kind  = EV_BODY;
                  res.first_start = span12(body_begin_in);
                  res.first_end   = span12(offset_ff + 1'b1);
               end else begin
                  res.event_kind = EV_ERROR;
               end
            end else if (adv_event) begin
               res_valid = 1'b1;
               res       = ev_res;
            end
         end
      end

      if (reset_all) begin
         phase_in        = PH_METHOD;
         offset_in       = '0;
         kstep_in        = '0;
         cand_in         = ALL_METHODS;
         target_begin_in = '0;
         name_begin_in   = '0;
         name_finish_in  = '0;
         value_begin_in  = '0;
         headers_in      = '0;
         body_begin_in   = '0;
         drop_in         = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_METHOD;
         offset_ff       <= '0;
         kstep_ff        <= '0;
         cand_ff         <= ALL_METHODS;
         target_begin_ff <= '0;
         name_begin_ff   <= '0;
         name_finish_ff  <= '0;
         value_begin_ff  <= '0;
         headers_ff      <= '0;
         body_begin_ff   <= '0;
         drop_ff         <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         offset_ff       <= offset_in;
         kstep_ff        <= kstep_in;
         cand_ff         <= cand_in;
         target_begin_ff <= target_begin_in;
         name_begin_ff   <= name_begin_in;
         name_finish_ff  <= name_finish_in;
         value_begin_ff  <= value_begin_in;
         headers_ff      <= headers_in;
         body_begin_ff   <= body_begin_in;
         drop_ff         <= drop_in;
      end
   end

endmodule

FILE: tb/tb_http_request_head_parser.sv
`timescale 1ns / 1ps

module tb_http_request_head_parser;
   import hrp_pkg::*;

   localparam int unsigned BUF_LIMIT    = 2048;
   localparam int unsigned HEADER_SLOTS = 32;
   // Length of the one long receiver hold-off, in clock cycles.
   localparam int unsigned LONG_HOLD    = 400;

   // The scoreboard follows the parser byte by byte. Every accepted input
   // beat is run through its own copy of the parser state, and any event that
   // byte must cause is queued. Every accepted output beat is then compared,
   // field by field, with the oldest queued event.
   class head_scoreboard;
      phase_type   phase;
      int unsigned offset;
      bit [2:0]    kstep;
      bit [8:0]    cand;
      int unsigned tgt_begin, nm_begin, nm_finish, val_begin, hdr_seen, body_begin;
      bit          dropping;
      string       version_word;
      result_type  expected_events[$];
      int unsigned mismatches, events_checked, bytes_parsed;
      int unsigned kind_count[4];

      function new();
         version_word = "HTTP/1.";
         mismatches = 0;
         events_checked = 0;
         bytes_parsed = 0;
         foreach (kind_count[i]) kind_count[i] = 0;
         clear();
      endfunction

      static function string method_word(int idx);
         case (idx)
            0: return "GET";
            1: return "POST";
            2: return "PUT";
            3: return "DELETE";
            4: return "OPTIONS";
            5: return "HEAD";
            6: return "CONNECT";
            7: return "PATCH";
            8: return "TRACE";
            default: return "";
         endcase
      endfunction

      function void clear();
         phase = PH_METHOD;
         offset = 0;
         kstep = 0;
         cand = '1;
         tgt_begin = 0;
         nm_begin = 0;
         nm_finish = 0;
         val_begin = 0;
         hdr_seen = 0;
         body_begin = 0;
         dropping = 1'b0;
      endfunction

      function result_type make_event(logic [1:0] kind, int unsigned meth, int unsigned a,
                                      int unsigned b, int unsigned c, int unsigned d,
                                      int unsigned hn);
         result_type e;
         e.event_kind    = kind;
         e.method_code   = meth[3:0];
         e.first_start   = a[11:0];
         e.first_end     = b[11:0];
         e.second_start  = c[11:0];
         e.second_end    = d[11:0];
         e.header_number = hn[4:0];
         return e;
      endfunction

      function int unsigned method_index();
         for (int i = 0; i < METHOD_COUNT; i++)
            if (cand[i]) return i;
         return 0;
      endfunction

      // Moves the grammar on by one byte. Returns -1 when the byte breaks the
      // grammar, 1 when it completes an event and 0 otherwise.
      function int parse(logic [7:0] c, int unsigned off, output result_type ev);
         bit [8:0] keep;
         int       hit;
         string    w;
         keep = '0;
         hit = -1;
         ev = '0;
         case (phase)
            PH_METHOD: begin
               for (int i = 0; i < METHOD_COUNT; i++) begin
                  if (cand[i]) begin
                     w = method_word(i);
                     if (kstep == w.len()) begin
                        if (c == CH_SPACE) hit = i;
                     end else if (kstep < w.len() && w[kstep] == c) begin
                        keep[i] = 1'b1;
                     end
                  end
               end
               if (hit >= 0) begin
                  cand = 9'd1 << hit;
                  tgt_begin = off + 1;
                  kstep = 0;
                  phase = PH_TARGET;
                  return 0;
               end
               if (keep == '0) return -1;
               cand = keep;
               kstep = kstep + 3'd1;
               return 0;
            end
            PH_TARGET: begin
               if (c == CH_SPACE) begin
                  nm_finish = off;
                  kstep = 0;
                  phase = PH_VERSION;
               end
               return 0;
            end
            PH_VERSION: begin
               if (kstep < 7) begin
                  if (version_word[kstep] != c) return -1;
                  kstep = kstep + 3'd1;
                  return 0;
               end
               if (c != CH_ONE && c != CH_ZERO) return -1;
               kstep = 0;
               phase = PH_START_CR;
               return 0;
            end
            PH_START_CR: begin
               if (c != CH_CR) return -1;
               phase = PH_START_LF;
               return 0;
            end
            PH_START_LF: begin
               if (c != CH_LF) return -1;
               ev = make_event(EV_START_LINE, method_index(), tgt_begin, nm_finish, 0, 0, 0);
               phase = PH_LINE;
               return 1;
            end
            PH_LINE: begin
               if (c == CH_CR) begin
                  phase = PH_BLANK_LF;
                  return 0;
               end
               if (hdr_seen >= HEADER_SLOTS) return -1;
               nm_begin = off;
               phase = PH_NAME;
               return 0;
            end
            PH_NAME: begin
               if (c == CH_COLON) begin
                  nm_finish = off;
                  phase = PH_VALUE_SP;
               end else if (c == CH_SPACE) begin
                  nm_finish = off;
                  phase = PH_NAME_COLON;
               end
               return 0;
            end
            PH_NAME_COLON: begin
               if (c != CH_COLON) return -1;
               phase = PH_VALUE_SP;
               return 0;
            end
            PH_VALUE_SP: begin
               if (c != CH_SPACE) return -1;
               val_begin = off + 1;
               phase = PH_VALUE;
               return 0;
            end
            PH_VALUE: begin
               if (c == CH_CR) phase = PH_VALUE_LF;
               return 0;
            end
            PH_VALUE_LF: begin
               if (c != CH_LF) return -1;
               ev = make_event(EV_HEADER, 0, nm_begin, nm_finish, val_begin, off - 1, hdr_seen);
               hdr_seen++;
               phase = PH_LINE;
               return 1;
            end
            PH_BLANK_LF: begin
               if (c != CH_LF) return -1;
               body_begin = off + 1;
               phase = PH_BODY;
               return 0;
            end
            PH_BODY: return 0;
            default: return -1;
         endcase
         return -1;
      endfunction

      function void note_byte(logic [7:0] c, logic is_last);
         int          r;
         result_type  ev;
         int unsigned off;
         off = offset;
         if (dropping) begin
            if (is_last) clear();
            return;
         end
         bytes_parsed++;
         if (off >= BUF_LIMIT) r = -1;
         else r = parse(c, off, ev);
         if (offset < BUF_LIMIT) offset++;
         if (r < 0) begin
            expected_events.push_back(make_event(EV_ERROR, 0, 0, 0, 0, 0, 0));
            if (is_last) clear();
            else dropping = 1'b1;
            return;
         end
         if (is_last) begin
            if (phase == PH_BODY)
               expected_events.push_back(make_event(EV_BODY, 0, body_begin, off + 1, 0, 0, 0));
            else
               expected_events.push_back(make_event(EV_ERROR, 0, 0, 0, 0, 0, 0));
            clear();
            return;
         end
         if (r > 0) expected_events.push_back(ev);
      endfunction

      function void check_field(string field, logic [11:0] want, logic [11:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
         end
      endfunction

      function void check_event(result_type got);
         result_type want;
         events_checked++;
         if (expected_events.size() == 0) begin
            $error("event of kind %0d arrived with nothing expected", got.event_kind);
            mismatches++;
            return;
         end
         want = expected_events.pop_front();
         kind_count[want.event_kind]++;
         check_field("event_kind", want.event_kind, got.event_kind);
         check_field("method_code", want.method_code, got.method_code);
         check_field("first_start", want.first_start, got.first_start);
         check_field("first_end", want.first_end, got.first_end);
         check_field("second_start", want.second_start, got.second_start);
         check_field("second_end", want.second_end, got.second_end);
         check_field("header_number", want.header_number, got.header_number);
      endfunction

      function int unsigned pending_count();
         return expected_events.size();
      endfunction
   endclass

   // Clock, reset and the block's ports. Inputs start at known values.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_event_kind;
   logic [3:0]  rsp_method_code;
   logic [11:0] rsp_first_start;
   logic [11:0] rsp_first_end;
   logic [11:0] rsp_second_start;
   logic [11:0] rsp_second_end;
   logic [4:0]  rsp_header_number;

   head_scoreboard sb;

   // Bytes of the request being built, sent as one beat each.
   logic [7:0]  req_bytes[$];
   int unsigned requests_sent = 0;

   // Idle control shared by the sender and the receiver. An odds value of N
   // means an idle burst starts with probability 1/N at each decision, and
   // zero means no idling at all. In the quiet tail nobody idles.
   int          idle_odds[4] = '{0, 2, 4, 10};
   int          tx_gap_odds = 0;
   int          rx_stall_odds = 4;
   bit          quiet_tail = 1'b0;
   bit          hold_rx = 1'b0;

   http_request_head_parser #(
      .BUF_BYTES   (BUF_LIMIT),
      .MAX_HEADERS (HEADER_SLOTS)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_method_code   (rsp_method_code),
      .rsp_first_start   (rsp_first_start),
      .rsp_first_end     (rsp_first_end),
      .rsp_second_start  (rsp_second_start),
      .rsp_second_end    (rsp_second_end),
      .rsp_header_number (rsp_header_number)
   );

   initial forever #6 clock = ~clock;

   // Both channels are sampled at the rising edge, where the values seen are
   // the ones that held just before it. A result always belongs to a byte
   // accepted at an earlier edge, so the order of the two calls is free.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_event({rsp_event_kind, rsp_method_code, rsp_first_start, rsp_first_end,
                            rsp_second_start, rsp_second_end, rsp_header_number});
         if (req_valid && req_ready)
            sb.note_byte(req_data_byte, req_last_byte);
      end
   end

   // The receiver decides its ready at each edge. Stalls come in bursts,
   // their frequency changes now and then, and once in the run the stimulus
   // asks for a long hold-off so that the block backs up.
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (hold_rx) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_rx = 1'b0;
         end else if (!quiet_tail && rx_stall_odds != 0 &&
                      $urandom_range(1, rx_stall_odds) == 1) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 63) == 0) rx_stall_odds = idle_odds[$urandom_range(0, 3)];
            @(posedge clock);
         end
      end
   end

   // Offers one byte and returns at the edge where it is accepted. An idle
   // burst, if one is drawn, comes before the byte so that valid never drops
   // while a byte is on offer.
   task automatic send_byte(input logic [7:0] data, input logic is_last);
      if (!quiet_tail && tx_gap_odds != 0 && $urandom_range(1, tx_gap_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= data;
      req_last_byte <= is_last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_request();
      for (int i = 0; i < req_bytes.size(); i++)
         send_byte(req_bytes[i], i == req_bytes.size() - 1);
      requests_sent++;
   endtask

   // Holds the sender back until every expected event has been taken.
   task automatic wait_for_events();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_count() != 0) @(posedge clock);
   endtask

   function automatic void add_byte(logic [7:0] b);
      req_bytes.push_back(b);
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) req_bytes.push_back(s[i]);
   endfunction

   function automatic void add_crlf();
      req_bytes.push_back(CH_CR);
      req_bytes.push_back(CH_LF);
   endfunction

   function automatic logic [7:0] byte_other_than(logic [7:0] a, logic [7:0] b);
      logic [7:0] v;
      v = 8'($urandom_range(0, 255));
      while (v == a || v == b) v = 8'($urandom_range(0, 255));
      return v;
   endfunction

   // Builds a well-formed request with random target, header names, values
   // and body. A body length of zero puts the last byte on the blank line's
   // LF, which gives an empty body span.
   function automatic void build_request(int meth, int n_hdr, int body_len);
      int tlen, nlen, vlen;
      req_bytes.delete();
      add_text(head_scoreboard::method_word(meth));
      add_byte(CH_SPACE);
      tlen = $urandom_range(0, 6);
      repeat (tlen) add_byte(byte_other_than(CH_SPACE, CH_SPACE));
      add_byte(CH_SPACE);
      add_text("HTTP/1.");
      add_byte($urandom_range(0, 1) ? CH_ONE : CH_ZERO);
      add_crlf();
      repeat (n_hdr) begin
         // The first name byte only has to differ from CR.
         add_byte(byte_other_than(CH_CR, CH_CR));
         nlen = $urandom_range(0, 5);
         repeat (nlen) add_byte(byte_other_than(CH_COLON, CH_SPACE));
         if ($urandom_range(0, 3) == 0) add_byte(CH_SPACE);
         add_byte(CH_COLON);
         add_byte(CH_SPACE);
         vlen = $urandom_range(0, 8);
         repeat (vlen) add_byte(byte_other_than(CH_CR, CH_CR));
         add_crlf();
      end
      add_crlf();
      repeat (body_len) add_byte(8'($urandom_range(0, 255)));
   endfunction

   initial begin
      int unsigned cut, pick;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed requests. Every method once, with and without headers and
      // with both an empty and a non-empty body.
      tx_gap_odds = 3;
      for (int m = 0; m < METHOD_COUNT; m++) begin
         build_request(m, m % 3, (m % 2) ? 0 : 4);
         send_request();
      end

      // A header name that ends at a space followed by the colon.
      req_bytes.delete();
      add_text("GET /a HTTP/1.0"); add_crlf();
      add_text("Host : x"); add_crlf(); add_crlf();
      send_request();

      // A space inside the name that is not followed by a colon. The rest of
      // the request is dropped up to its last byte.
      req_bytes.delete();
      add_text("GET / HTTP/1.1"); add_crlf();
      add_text("Host x"); add_crlf(); add_crlf(); add_text("zz");
      send_request();

      // No space after the colon.
      req_bytes.delete();
      add_text("PUT / HTTP/1.1"); add_crlf();
      add_text("A:b"); add_crlf(); add_crlf();
      send_request();

      // Unsupported minor version.
      req_bytes.delete();
      add_text("HEAD / HTTP/1.2"); add_crlf();
      send_request();

      // Unknown method.
      req_bytes.delete();
      add_text("GEX / HTTP/1.1"); add_crlf(); add_crlf();
      send_request();

      // The request ends in the middle of a header value.
      req_bytes.delete();
      add_text("POST /x HTTP/1.1"); add_crlf();
      add_text("Ab: c");
      send_request();

      // A single bad byte that is also the last one.
      req_bytes.delete();
      add_text("Z");
      send_request();

      // A CR on the blank line that is not followed by LF.
      req_bytes.delete();
      add_text("GET / HTTP/1.1"); add_crlf();
      add_byte(CH_CR); add_text("XY");
      send_request();

      // A start line closed by LF alone.
      req_bytes.delete();
      add_text("GET / HTTP/1.1"); add_byte(CH_LF); add_crlf();
      send_request();

      // Extreme byte values in the target and the value, and a name that
      // starts with a colon.
      req_bytes.delete();
      add_text("TRACE "); add_byte(8'h00); add_byte(8'hFF); add_byte(CH_CR);
      add_text(" HTTP/1.0"); add_crlf();
      add_text(":: "); add_byte(8'h00); add_byte(8'hFF); add_byte(CH_LF); add_crlf();
      add_crlf(); add_byte(8'h80);
      send_request();

      // All header slots used while the receiver holds off for a long time.
      // The sender keeps offering bytes, so the block fills and stalls req_.
      hold_rx = 1'b1;
      build_request(1, HEADER_SLOTS, 2);
      send_request();

      // One header more than there are slots.
      build_request(2, HEADER_SLOTS + 1, 2);
      send_request();

      // Pure noise.
      req_bytes.delete();
      repeat (20) add_byte(8'($urandom_range(0, 255)));
      send_request();

      wait_for_events();

      // Random requests: mostly well-formed with random content, the rest cut
      // short, corrupted in one byte, or noise.
      repeat (10) begin
         tx_gap_odds = idle_odds[$urandom_range(0, 3)];
         build_request($urandom_range(0, METHOD_COUNT - 1),
                       ($urandom_range(0, 99) < 3) ? $urandom_range(30, 34) :
                                                     $urandom_range(0, 4),
                       ($urandom_range(0, 99) < 25) ? 0 : $urandom_range(1, 12));
         pick = $urandom_range(0, 99);
         if (pick >= 65 && pick < 80) begin
            cut = $urandom_range(1, req_bytes.size());
            req_bytes = req_bytes[0:cut-1];
         end else if (pick >= 80 && pick < 92) begin
            req_bytes[$urandom_range(0, req_bytes.size() - 1)] = 8'($urandom_range(0, 255));
         end else if (pick >= 92) begin
            req_bytes.delete();
            repeat ($urandom_range(1, 20)) add_byte(8'($urandom_range(0, 255)));
         end
         send_request();
         if ($urandom_range(0, 29) == 0) wait_for_events();
      end

      // A last stretch with both sides running flat out.
      quiet_tail = 1'b1;
      repeat (4) begin
         build_request($urandom_range(0, METHOD_COUNT - 1), $urandom_range(0, 3),
                       $urandom_range(0, 6));
         send_request();
      end

      wait_for_events();
      repeat (8) @(posedge clock);

      $display("Run covered %0d requests, %0d bytes parsed, %0d events checked.",
               requests_sent, sb.bytes_parsed, sb.events_checked);
      $display("Events by kind: %0d start lines, %0d headers, %0d bodies, %0d errors.",
               sb.kind_count[EV_START_LINE], sb.kind_count[EV_HEADER],
               sb.kind_count[EV_BODY], sb.kind_count[EV_ERROR]);
      if (sb.mismatches == 0) begin
         $display("[http_request_head_parser] OK");
      end else begin
         $display("[http_request_head_parser] ERROR");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #30_000_000;
      $display("Timeout with %0d events still expected.", sb.pending_count());
      $display("[http_request_head_parser] ERROR");
      $finish;
   end

endmodule
